// ----- rtl/flpte_pkg.sv -----
// shared types, codes and sizes of the four-level page table engine
// no dependencies; used by flpte_ctrl, flpte_dpath and the top level
`default_nettype none

package flpte_pkg;

    localparam int POOL_PAGES    = 64;
    localparam int TABLE_ENTRIES = 512;

    localparam int PAGE_W  = $clog2(POOL_PAGES);
    localparam int IDX_W   = $clog2(TABLE_ENTRIES);
    localparam int ADDR_W  = PAGE_W + IDX_W;
    localparam int NFP_W   = $clog2(POOL_PAGES + 1);
    localparam int BASE_W  = 40;
    localparam int LEVEL_W = 2;

    localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(256);

    // request codes
    localparam logic [2:0] FN_MAP       = 3'd0;
    localparam logic [2:0] FN_UNMAP     = 3'd1;
    localparam logic [2:0] FN_PROTECT   = 3'd2;
    localparam logic [2:0] FN_GET_FLAGS = 3'd3;
    localparam logic [2:0] FN_TRANSLATE = 3'd4;

    // status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_VUNAL   = 3'd1;
    localparam logic [2:0] ST_PUNAL   = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_HUGE    = 3'd4;
    localparam logic [2:0] ST_ABSENT  = 3'd5;
    localparam logic [2:0] ST_MAPPED  = 3'd6;
    localparam logic [2:0] ST_FOREIGN = 3'd7;

    localparam logic [LEVEL_W-1:0] LEVEL_LEAF = 2'd3;

    localparam logic [63:0] PG_MASK    = 64'hFFFF_FFFF_FFFF_F000;
    localparam logic [63:0] FRAME_MASK = 64'h000F_FFFF_FFFF_F000;
    localparam logic [63:0] KEEP_MASK  = 64'h8000_0000_0000_011E;
    localparam logic [63:0] READ_MASK  = 64'h8000_0000_0000_01FF;
    localparam logic [63:0] LINK_FLAGS = 64'h0000_0000_0000_0003;

    localparam int BIT_PRESENT = 0;
    localparam int BIT_HUGE    = 7;

    // controller to datapath
    typedef struct packed {
        logic               load;
        logic               pre;
        logic               rd;
        logic               eval;
        logic               emit;
        logic               clr_wr;
        logic [ADDR_W-1:0]  clr_addr;
        logic [LEVEL_W-1:0] level;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic pre_done;
        logic ev_done;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// ----- rtl/four_level_page_table_engine.sv -----
// top level of the four-level page table engine
// depends on flpte_pkg, flpte_ctrl and flpte_dpath
//
// requests enter on i_req_valid / o_req_stall with i_func, i_virt_addr,
// i_phys_addr and i_page_flags; one response per request leaves on
// o_rsp_valid / i_rsp_stall with o_ok, o_status and o_result_value.
// o_cfg_ready is always high; i_cfg_pool_base_page is written on i_cfg_valid
// and should only change while no request is in flight.
// after reset the table memory is zeroed one entry a cycle, all 32768 entries,
// with o_req_stall high; next free page resets to 1, pool base to 256.
// one request at a time: a request rejected before the walk goes from its
// check step straight to hand-off; a full walk runs a check step, a read
// and an evaluate step for each of the four levels and a hand-off step,
// with read and evaluate split by the registered read of the table memory.
// the next request is accepted the cycle after a response is handed to the
// output register.
// a finished response sits in the output register while i_rsp_stall is
// high; the next request can be accepted meanwhile, but its response waits
// until the output register has been taken.
`default_nettype none

module four_level_page_table_engine (
    input  wire  logic                          i_clk,
    input  wire  logic                          i_rst_n,
    input  wire  logic                          i_req_valid,
    output logic                                o_req_stall,
    input  wire  logic [2:0]                    i_func,
    input  wire  logic [47:0]                   i_virt_addr,
    input  wire  logic [51:0]                   i_phys_addr,
    input  wire  logic [63:0]                   i_page_flags,
    output logic                                o_rsp_valid,
    input  wire  logic                          i_rsp_stall,
    output logic                                o_ok,
    output logic [2:0]                          o_status,
    output logic [63:0]                         o_result_value,
    input  wire  logic                          i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  logic [flpte_pkg::BASE_W-1:0]  i_cfg_pool_base_page
);

    flpte_pkg::t_cmd cmd;
    flpte_pkg::t_sts sts;

    flpte_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_cmd       (cmd),
        .i_sts       (sts),
        .o_req_stall (o_req_stall)
    );

    flpte_dpath u_dpath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .o_sts                (sts),
        .i_cfg_valid          (i_cfg_valid),
        .i_cfg_pool_base_page (i_cfg_pool_base_page),
        .i_func               (i_func),
        .i_virt_addr          (i_virt_addr),
        .i_phys_addr          (i_phys_addr),
        .i_page_flags         (i_page_flags),
        .i_rsp_stall          (i_rsp_stall),
        .o_rsp_valid          (o_rsp_valid),
        .o_ok                 (o_ok),
        .o_status             (o_status),
        .o_result_value       (o_result_value)
    );

    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

// ----- rtl/flpte_ctrl.sv -----
// sequencer of the page table engine: clearing pass, walk levels, result hand-off
// depends on flpte_pkg
`default_nettype none

module flpte_ctrl (
    input  wire                logic i_clk,
    input  wire                logic i_rst_n,
    input  wire                logic i_req_valid,
    output flpte_pkg::t_cmd    o_cmd,
    input  wire flpte_pkg::t_sts i_sts,
    output logic               o_req_stall
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_EVAL  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]                          r_state, n_state;
    logic [flpte_pkg::LEVEL_W-1:0]       r_level, n_level;
    logic [flpte_pkg::ADDR_W-1:0]        r_clr, n_clr;

    always_comb begin
        n_state      = r_state;
        n_level      = r_level;
        n_clr        = r_clr;
        o_cmd        = '0;
        o_cmd.level  = r_level;
        o_cmd.clr_addr = r_clr;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                n_clr = r_clr + 1'b1;
                if (&r_clr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.pre = 1'b1;
                n_level = '0;
                n_state = i_sts.pre_done ? S_DONE : S_READ;
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state = S_EVAL;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                if (i_sts.ev_done) begin
                    n_state = S_DONE;
                end else begin
                    n_level = r_level + 1'b1;
                    n_state = S_READ;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_level <= '0;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_level <= n_level;
            r_clr   <= n_clr;
        end
    end

    assign o_req_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

// ----- rtl/flpte_dpath.sv -----
// datapath of the page table engine: request registers, table memory,
// bump allocator, entry evaluation and result register; depends on flpte_pkg
`default_nettype none

module flpte_dpath (
    input  wire  flpte_pkg::t_cmd               i_cmd,
    input  wire  logic                          i_clk,
    input  wire  logic                          i_rst_n,
    output flpte_pkg::t_sts                     o_sts,
    input  wire  logic                          i_cfg_valid,
    input  wire  logic [flpte_pkg::BASE_W-1:0]  i_cfg_pool_base_page,
    input  wire  logic [2:0]                    i_func,
    input  wire  logic [47:0]                   i_virt_addr,
    input  wire  logic [51:0]                   i_phys_addr,
    input  wire  logic [63:0]                   i_page_flags,
    input  wire  logic                          i_rsp_stall,
    output logic                                o_rsp_valid,
    output logic                                o_ok,
    output logic [2:0]                          o_status,
    output logic [63:0]                         o_result_value
);

    localparam int PW = flpte_pkg::PAGE_W;
    localparam int AW = flpte_pkg::ADDR_W;
    localparam int IW = flpte_pkg::IDX_W;
    localparam int NW = flpte_pkg::NFP_W;
    localparam int BW = flpte_pkg::BASE_W;

    logic [63:0]   r_mem [flpte_pkg::POOL_PAGES * flpte_pkg::TABLE_ENTRIES];
    logic [63:0]   r_rdata;
    logic [AW-1:0] r_slot;

    logic [2:0]    r_func;
    logic [47:0]   r_va;
    logic [51:0]   r_pa;
    logic [63:0]   r_fl;

    logic [BW-1:0] r_base;
    logic [NW-1:0] r_nfp;
    logic [PW-1:0] r_page, n_page;

    logic          r_res_ok, n_res_ok;
    logic [2:0]    r_res_st, n_res_st;
    logic [63:0]   r_res_val, n_res_val;

    logic          r_out_valid;

    logic [IW-1:0] idx;
    logic [AW-1:0] rd_addr;

    logic          pre_done;
    logic [2:0]    pre_code;
    logic          pre_ok;

    logic          ev_done;
    logic          ev_fail;
    logic [2:0]    ev_code;
    logic [63:0]   ev_val;
    logic          wr_en;
    logic [63:0]   wr_data;
    logic          alloc;

    logic [63:0]   e;
    logic          present;
    logic [BW:0]   rel;
    logic          foreign;
    logic [BW-1:0] link_page;
    logic [63:0]   fl_keep;

    // table index for the current walk level
    always_comb begin
        case (i_cmd.level)
            2'd0:    idx = r_va[47:39];
            2'd1:    idx = r_va[38:30];
            2'd2:    idx = r_va[29:21];
            default: idx = r_va[20:12];
        endcase
    end

    assign rd_addr = {r_page, idx};

    always_comb begin
        pre_done = 1'b1;
        pre_ok   = 1'b0;
        pre_code = flpte_pkg::ST_OK;
        if (r_func > flpte_pkg::FN_TRANSLATE) begin
            pre_code = flpte_pkg::ST_OK;
        end else if (r_va[11:0] != 12'd0) begin
            pre_code = flpte_pkg::ST_VUNAL;
        end else if (r_func == flpte_pkg::FN_MAP && r_pa[11:0] != 12'd0) begin
            pre_code = flpte_pkg::ST_PUNAL;
        end else begin
            pre_done = 1'b0;
        end
    end

    assign e         = r_rdata;
    assign present   = e[flpte_pkg::BIT_PRESENT];
    // relative pool page; a borrow means below the pool
    assign rel       = {1'b0, e[51:12]} - {1'b0, r_base};
    assign foreign   = rel[BW] || (rel[BW-1:0] >= BW'(r_nfp));
    assign link_page = r_base + BW'(r_nfp);
    assign fl_keep   = r_fl & flpte_pkg::KEEP_MASK;

    always_comb begin
        ev_fail = 1'b0;
        ev_code = flpte_pkg::ST_OK;
        ev_val  = '0;
        wr_en   = 1'b0;
        wr_data = '0;
        alloc   = 1'b0;
        n_page  = r_page;
        if (i_cmd.level != flpte_pkg::LEVEL_LEAF) begin
            if (!present) begin
                if (r_func != flpte_pkg::FN_MAP) begin
                    ev_fail = 1'b1;
                    ev_code = flpte_pkg::ST_ABSENT;
                end else if (r_nfp == NW'(flpte_pkg::POOL_PAGES)) begin
                    ev_fail = 1'b1;
                    ev_code = flpte_pkg::ST_FULL;
                end else begin
                    alloc   = 1'b1;
                    wr_en   = 1'b1;
                    wr_data = {12'd0, link_page, 12'd0} | flpte_pkg::LINK_FLAGS;
                    n_page  = r_nfp[PW-1:0];
                end
            end else if (i_cmd.level != '0 && e[flpte_pkg::BIT_HUGE]) begin
                ev_fail = 1'b1;
                ev_code = flpte_pkg::ST_HUGE;
            end else if (foreign) begin
                ev_fail = 1'b1;
                ev_code = flpte_pkg::ST_FOREIGN;
            end else begin
                n_page = rel[PW-1:0];
            end
        end else begin
            if (r_func == flpte_pkg::FN_MAP) begin
                if (present) begin
                    ev_fail = 1'b1;
                    ev_code = flpte_pkg::ST_MAPPED;
                end else begin
                    wr_en   = 1'b1;
                    wr_data = ({12'd0, r_pa} & flpte_pkg::PG_MASK) | fl_keep | 64'd1;
                end
            end else if (!present) begin
                ev_fail = 1'b1;
                ev_code = flpte_pkg::ST_ABSENT;
            end else begin
                case (r_func)
                    flpte_pkg::FN_UNMAP: begin
                        wr_en   = 1'b1;
                        wr_data = '0;
                    end
                    flpte_pkg::FN_PROTECT: begin
                        wr_en   = 1'b1;
                        wr_data = (e & ~flpte_pkg::KEEP_MASK) | fl_keep;
                    end
                    flpte_pkg::FN_GET_FLAGS: begin
                        ev_val = e & flpte_pkg::READ_MASK;
                    end
                    default: begin
                        ev_val = e & flpte_pkg::FRAME_MASK;
                    end
                endcase
            end
        end
        ev_done = ev_fail || (i_cmd.level == flpte_pkg::LEVEL_LEAF);
    end

    always_comb begin
        n_res_ok  = r_res_ok;
        n_res_st  = r_res_st;
        n_res_val = r_res_val;
        if (i_cmd.pre) begin
            n_res_ok  = pre_ok;
            n_res_st  = pre_code;
            n_res_val = '0;
        end else if (i_cmd.eval && ev_done) begin
            n_res_ok  = !ev_fail;
            n_res_st  = ev_code;
            n_res_val = ev_fail ? 64'd0 : ev_val;
        end
    end

    // table memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            r_mem[i_cmd.clr_addr] <= '0;
        end else if (i_cmd.eval && wr_en) begin
            r_mem[r_slot] <= wr_data;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[rd_addr];
            r_slot  <= rd_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_va   <= i_virt_addr;
            r_pa   <= i_phys_addr;
            r_fl   <= i_page_flags;
        end
        if (i_cmd.load) begin
            r_page <= '0;
        end else if (i_cmd.eval) begin
            r_page <= n_page;
        end
        r_res_ok  <= n_res_ok;
        r_res_st  <= n_res_st;
        r_res_val <= n_res_val;
        if (i_cmd.emit) begin
            o_ok           <= r_res_ok;
            o_status       <= r_res_st;
            o_result_value <= r_res_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= flpte_pkg::BASE_RESET;
            r_nfp       <= NW'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_base <= i_cfg_pool_base_page;
            end
            if (i_cmd.eval && alloc) begin
                r_nfp <= r_nfp + 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_rsp_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_rsp_valid    = r_out_valid;
    assign o_sts.pre_done = pre_done;
    assign o_sts.ev_done  = ev_done;
    assign o_sts.out_free = !r_out_valid || !i_rsp_stall;

endmodule

`default_nettype wire

// ----- test/page_table_response_checker.sv -----
`timescale 1ns / 100ps
// response checker for four_level_page_table_engine: watches the request,
// response and pool base channels, predicts each response and compares it
// depends on flpte_pkg for sizes, masks, request and status codes
module page_table_response_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_req_valid,
    input  wire logic                          i_req_stall,
    input  wire logic [2:0]                    i_func,
    input  wire logic [47:0]                   i_virt_addr,
    input  wire logic [51:0]                   i_phys_addr,
    input  wire logic [63:0]                   i_page_flags,
    input  wire logic                          i_rsp_valid,
    input  wire logic                          i_rsp_stall,
    input  wire logic                          i_ok,
    input  wire logic [2:0]                    i_status,
    input  wire logic [63:0]                   i_result_value,
    input  wire logic                          i_cfg_valid,
    input  wire logic                          i_cfg_ready,
    input  wire logic [flpte_pkg::BASE_W-1:0]  i_cfg_pool_base_page,
    output int                                 o_mismatches,
    output int                                 o_outstanding,
    output int                                 o_checked,
    output logic [7:0]                         o_status_seen
);

    localparam int          OFS_BITS     = 12;
    localparam int          ENTRIES      = flpte_pkg::TABLE_ENTRIES;
    localparam int          IW           = flpte_pkg::IDX_W;
    localparam int          LEAF         = int'(flpte_pkg::LEVEL_LEAF);
    localparam logic [63:0] PRESENT_FLAG = 64'd1 << flpte_pkg::BIT_PRESENT;
    localparam logic [63:0] KEEP         = flpte_pkg::KEEP_MASK;

    typedef struct packed {
        logic        ok;
        logic [2:0]  status;
        logic [63:0] value;
    } t_page_rsp;

    logic [63:0]                  table_mem [flpte_pkg::POOL_PAGES*ENTRIES];
    int unsigned                  alloc_next;
    logic [flpte_pkg::BASE_W-1:0] pool_base;
    t_page_rsp                    pending_rsp [$];
    t_page_rsp                    exp_rsp;

    // walk pml4, pdpt and pd; on success leaf_page is the pool page of the page table
    function automatic logic [2:0] walk_to_leaf(input logic [47:0] va, input logic create,
                                                output int unsigned leaf_page);
        int unsigned page;
        int unsigned slot;
        int          shift;
        logic [63:0] entry;
        logic [63:0] rel_page;
        page = 0;
        leaf_page = 0;
        for (int level = 0; level < LEAF; level++) begin
            shift = OFS_BITS + IW * (LEAF - level);
            slot = page * ENTRIES + 32'(va[shift +: IW]);
            entry = table_mem[slot];
            if (!entry[flpte_pkg::BIT_PRESENT]) begin
                if (!create) return flpte_pkg::ST_ABSENT;
                if (alloc_next >= flpte_pkg::POOL_PAGES) return flpte_pkg::ST_FULL;
                for (int i = 0; i < ENTRIES; i++)
                    table_mem[alloc_next * ENTRIES + i] = '0;
                table_mem[slot] = (((64'(pool_base) + 64'(alloc_next)) << OFS_BITS)
                                   & flpte_pkg::FRAME_MASK) | flpte_pkg::LINK_FLAGS;
                page = alloc_next;
                alloc_next = alloc_next + 1;
            end else begin
                // the huge bit only counts below the root
                if (level > 0 && entry[flpte_pkg::BIT_HUGE]) return flpte_pkg::ST_HUGE;
                rel_page = ((entry & flpte_pkg::FRAME_MASK) >> OFS_BITS) - 64'(pool_base);
                if (rel_page >= 64'(alloc_next)) return flpte_pkg::ST_FOREIGN;
                page = rel_page[31:0];
            end
        end
        leaf_page = page;
        return flpte_pkg::ST_OK;
    endfunction

    function automatic t_page_rsp predict_page_request(input logic [2:0] fn,
                                                       input logic [47:0] va,
                                                       input logic [51:0] pa,
                                                       input logic [63:0] flags);
        t_page_rsp   rsp;
        logic [2:0]  st;
        logic [63:0] value;
        logic [63:0] entry;
        int unsigned leaf_page;
        int unsigned slot;
        st = flpte_pkg::ST_OK;
        value = '0;
        rsp = '0;
        if (fn > flpte_pkg::FN_TRANSLATE) return rsp;
        if (va[OFS_BITS-1:0] != '0) begin
            st = flpte_pkg::ST_VUNAL;
        end else if (fn == flpte_pkg::FN_MAP && pa[OFS_BITS-1:0] != '0) begin
            st = flpte_pkg::ST_PUNAL;
        end else begin
            st = walk_to_leaf(va, fn == flpte_pkg::FN_MAP, leaf_page);
            if (st == flpte_pkg::ST_OK) begin
                slot = leaf_page * ENTRIES + 32'(va[OFS_BITS +: IW]);
                entry = table_mem[slot];
                if (fn == flpte_pkg::FN_MAP) begin
                    if (entry[flpte_pkg::BIT_PRESENT])
                        st = flpte_pkg::ST_MAPPED;
                    else
                        table_mem[slot] = (64'(pa) & flpte_pkg::PG_MASK) | (flags & KEEP)
                                          | PRESENT_FLAG;
                end else if (!entry[flpte_pkg::BIT_PRESENT]) begin
                    st = flpte_pkg::ST_ABSENT;
                end else if (fn == flpte_pkg::FN_UNMAP) begin
                    table_mem[slot] = '0;
                end else if (fn == flpte_pkg::FN_PROTECT) begin
                    table_mem[slot] = (entry & ~KEEP) | (flags & KEEP);
                end else if (fn == flpte_pkg::FN_GET_FLAGS) begin
                    value = entry & flpte_pkg::READ_MASK;
                end else begin
                    value = (entry & flpte_pkg::FRAME_MASK) | 64'(va[OFS_BITS-1:0]);
                end
            end
        end
        rsp.ok = (st == flpte_pkg::ST_OK);
        rsp.status = st;
        rsp.value = rsp.ok ? value : '0;
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (table_mem[i]) table_mem[i] = '0;
            alloc_next = 1;
            pool_base = flpte_pkg::BASE_RESET;
            pending_rsp.delete();
            o_mismatches = 0;
            o_checked = 0;
            o_status_seen = '0;
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                pool_base = i_cfg_pool_base_page;
            if (i_rsp_valid && !i_rsp_stall) begin
                if (pending_rsp.size() == 0) begin
                    $display("%0t: unexpected response, expected none, got %0d %0d %h",
                             $time, i_ok, i_status, i_result_value);
                    o_mismatches++;
                end else begin
                    exp_rsp = pending_rsp.pop_front();
                    o_checked++;
                    o_status_seen[exp_rsp.status] = 1'b1;
                    if (i_ok !== exp_rsp.ok) begin
                        $display("%0t: ok mismatch, expected %0d, got %0d",
                                 $time, exp_rsp.ok, i_ok);
                        o_mismatches++;
                    end
                    if (i_status !== exp_rsp.status) begin
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, exp_rsp.status, i_status);
                        o_mismatches++;
                    end
                    if (i_result_value !== exp_rsp.value) begin
                        $display("%0t: result value mismatch, expected %h, got %h",
                                 $time, exp_rsp.value, i_result_value);
                        o_mismatches++;
                    end
                end
            end
            if (i_req_valid && !i_req_stall)
                pending_rsp.push_back(predict_page_request(i_func, i_virt_addr,
                                                           i_phys_addr, i_page_flags));
        end
        o_outstanding = pending_rsp.size();
    end

endmodule

// ----- test/four_level_page_table_engine_tb.sv -----
`timescale 1ns / 100ps
// top of the page table engine testbench: clock, reset, request and pool base stimulus
// depends on flpte_pkg, four_level_page_table_engine and page_table_response_checker
module four_level_page_table_engine_tb;

    localparam int                BW               = flpte_pkg::BASE_W;
    localparam logic [2:0]        FN_MAP           = flpte_pkg::FN_MAP;
    localparam logic [2:0]        FN_UNMAP         = flpte_pkg::FN_UNMAP;
    localparam logic [2:0]        FN_PROTECT       = flpte_pkg::FN_PROTECT;
    localparam logic [2:0]        FN_GET_FLAGS     = flpte_pkg::FN_GET_FLAGS;
    localparam logic [2:0]        FN_TRANSLATE     = flpte_pkg::FN_TRANSLATE;
    localparam logic [2:0]        FN_SPARE_5       = 3'd5;
    localparam logic [2:0]        FN_SPARE_6       = 3'd6;
    localparam logic [2:0]        FN_SPARE_7       = 3'd7;
    localparam logic [BW-1:0]     BASE_TOP         = 40'hFF_FFFF_FFC0;
    localparam int                GAP_MAX          = 8;
    localparam int                SENDER           = 0;
    localparam int                RECEIVER         = 1;
    localparam int                LONG_HOLD_CYCLES = 120;
    localparam int                HOLD_AT_FIRST    = 80;
    localparam int                HOLD_AT_SECOND   = 320;
    localparam int                DRAIN_CYCLES     = 16;
    localparam int                HOT_REGIONS      = 8;
    localparam int                TIMEOUT_NS       = 2_000_000;

    logic              clk;
    logic              rst_n      = 1'b0;
    logic              req_valid  = 1'b0;
    logic              req_stall;
    logic [2:0]        req_func   = FN_MAP;
    logic [47:0]       req_va     = '0;
    logic [51:0]       req_pa     = '0;
    logic [63:0]       req_flags  = '0;
    logic              rsp_valid;
    logic              rsp_stall  = 1'b0;
    logic              rsp_ok;
    logic [2:0]        rsp_status;
    logic [63:0]       rsp_value;
    logic              cfg_valid  = 1'b0;
    logic              cfg_ready;
    logic [BW-1:0]     cfg_base   = flpte_pkg::BASE_RESET;

    int                mismatches;
    int                outstanding;
    int                checked;
    logic [7:0]        status_seen;

    int                sent_count = 0;
    int                base_writes = 0;
    int                run_left [2] = '{0, 0};
    bit                zero_wait_run [2] = '{1'b0, 1'b0};
    logic [26:0]       hot_prefix [HOT_REGIONS];

    four_level_page_table_engine dut (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_req_valid          (req_valid),
        .o_req_stall          (req_stall),
        .i_func               (req_func),
        .i_virt_addr          (req_va),
        .i_phys_addr          (req_pa),
        .i_page_flags         (req_flags),
        .o_rsp_valid          (rsp_valid),
        .i_rsp_stall          (rsp_stall),
        .o_ok                 (rsp_ok),
        .o_status             (rsp_status),
        .o_result_value       (rsp_value),
        .i_cfg_valid          (cfg_valid),
        .o_cfg_ready          (cfg_ready),
        .i_cfg_pool_base_page (cfg_base)
    );

    page_table_response_checker u_rsp_check (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_req_valid          (req_valid),
        .i_req_stall          (req_stall),
        .i_func               (req_func),
        .i_virt_addr          (req_va),
        .i_phys_addr          (req_pa),
        .i_page_flags         (req_flags),
        .i_rsp_valid          (rsp_valid),
        .i_rsp_stall          (rsp_stall),
        .i_ok                 (rsp_ok),
        .i_status             (rsp_status),
        .i_result_value       (rsp_value),
        .i_cfg_valid          (cfg_valid),
        .i_cfg_ready          (cfg_ready),
        .i_cfg_pool_base_page (cfg_base),
        .o_mismatches         (mismatches),
        .o_outstanding        (outstanding),
        .o_checked            (checked),
        .o_status_seen        (status_seen)
    );

    always begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // waits come in runs: some runs never wait, the rest draw 0 to GAP_MAX per request or response
    function automatic int draw_wait(input int side);
        if (run_left[side] == 0) begin
            run_left[side] = $urandom_range(8, 30);
            zero_wait_run[side] = ($urandom_range(0, 3) == 0);
        end
        run_left[side] = run_left[side] - 1;
        return zero_wait_run[side] ? 0 : $urandom_range(0, GAP_MAX);
    endfunction

    task automatic send_request(input logic [2:0] fn, input logic [47:0] va,
                                input logic [51:0] pa, input logic [63:0] flags);
        int gap;
        gap = draw_wait(SENDER);
        @(negedge clk);
        if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req_func  <= fn;
        req_va    <= va;
        req_pa    <= pa;
        req_flags <= flags;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        sent_count++;
    endtask

    task automatic send_random_request(input int fresh_pct);
        logic [2:0]  fn;
        logic [47:0] va;
        logic [51:0] pa;
        logic [63:0] flags;
        int          roll;
        roll = $urandom_range(0, 99);
        if (roll < 36)      fn = FN_MAP;
        else if (roll < 50) fn = FN_UNMAP;
        else if (roll < 63) fn = FN_PROTECT;
        else if (roll < 80) fn = FN_GET_FLAGS;
        else if (roll < 97) fn = FN_TRANSLATE;
        else                fn = 3'($urandom_range(FN_SPARE_5, FN_SPARE_7));
        // mostly a few hot paths so that maps and lookups meet on the same pages
        va = {hot_prefix[$urandom_range(0, HOT_REGIONS - 1)],
              9'($urandom_range(0, ($urandom_range(0, 9) == 0) ? 511 : 15)), 12'h000};
        if ($urandom_range(0, 99) < fresh_pct)
            va = {4'($urandom), 32'($urandom), 12'h000};
        if ($urandom_range(0, 99) < 4)
            va[11:0] = 12'($urandom_range(1, 4095));
        pa = {20'($urandom), 32'($urandom)};
        if ($urandom_range(0, 99) >= 5)
            pa[11:0] = '0;
        flags = {$urandom, $urandom};
        send_request(fn, va, pa, flags);
    endtask

    task automatic run_random_phase(input int count, input int fresh_pct);
        repeat (count) send_random_request(fresh_pct);
    endtask

    // hold requests back until every response has come home
    task automatic drain_requests();
        @(negedge clk);
        req_valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
    endtask

    task automatic write_pool_base(input logic [BW-1:0] base);
        drain_requests();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_base  <= base;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        base_writes++;
    endtask

    initial begin : response_sink
        int hold;
        int taken;
        taken = 0;
        forever begin
            hold = draw_wait(RECEIVER);
            // long hold lets the engine fill its output and stall requests
            if (taken == HOLD_AT_FIRST || taken == HOLD_AT_SECOND)
                hold = LONG_HOLD_CYCLES;
            @(negedge clk);
            if (hold > 0) begin
                rsp_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            rsp_stall <= 1'b0;
            @(posedge clk);
            while (!rsp_valid) @(posedge clk);
            taken++;
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("timeout: engine stopped making progress");
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        hot_prefix[0] = '0;
        hot_prefix[1] = '1;
        for (int i = 2; i < HOT_REGIONS; i++)
            hot_prefix[i] = 27'($urandom);
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty tables: every lookup misses at the root
        send_request(FN_TRANSLATE, 48'h0, 52'h0, 64'h0);
        send_request(FN_GET_FLAGS, 48'h0, 52'h0, 64'h0);
        send_request(FN_UNMAP, 48'h0, 52'h0, 64'h0);
        send_request(FN_PROTECT, 48'h0, 52'h0, '1);
        // virtual alignment wins over physical alignment
        send_request(FN_MAP, 48'h0000_0000_1001, 52'h0_0000_0000_2001, '1);
        send_request(FN_MAP, 48'h0000_0000_0800, 52'h0, 64'h0);
        send_request(FN_MAP, 48'h0, 52'h0_0000_0000_0FFF, 64'h0);
        send_request(FN_MAP, 48'h0, 52'hF_FFFF_FFFF_F000, '1);
        send_request(FN_MAP, 48'h0, 52'h0_0000_0000_1000, 64'h0);
        send_request(FN_GET_FLAGS, 48'h0, 52'h0, 64'h0);
        // physical alignment only matters for map
        send_request(FN_TRANSLATE, 48'h0, 52'h0_0000_0000_0ABC, 64'h0);
        send_request(FN_PROTECT, 48'h0, 52'h0, ~flpte_pkg::KEEP_MASK);
        send_request(FN_GET_FLAGS, 48'h0, 52'h0, 64'h0);
        send_request(FN_PROTECT, 48'h0, 52'h0, '1);
        send_request(FN_GET_FLAGS, 48'h0, 52'h0, 64'h0);
        send_request(FN_UNMAP, 48'h0, 52'h0, 64'h0);
        send_request(FN_TRANSLATE, 48'h0, 52'h0, 64'h0);
        send_request(FN_UNMAP, 48'h0, 52'h0, 64'h0);
        send_request(FN_MAP, 48'hFFFF_FFFF_F000, 52'h0, 64'h0);
        send_request(FN_TRANSLATE, 48'hFFFF_FFFF_F000, '1, 64'h0);
        send_request(FN_GET_FLAGS, 48'hFFFF_FFFF_E000, 52'h0, 64'h0);
        send_request(FN_SPARE_5, 48'h0000_0000_0123, 52'h1, '1);
        send_request(FN_SPARE_6, 48'h0, 52'h0, 64'h0);
        send_request(FN_SPARE_7, 48'hFFFF_FFFF_F000, '1, '1);

        run_random_phase(170, 6);
        // old tables turn foreign under a moved pool base
        write_pool_base('0);
        run_random_phase(50, 10);
        write_pool_base(BASE_TOP);
        run_random_phase(40, 10);
        write_pool_base(40'h55_5555_5555);
        run_random_phase(25, 10);
        write_pool_base(40'hAA_AAAA_AAAA);
        run_random_phase(25, 10);
        write_pool_base({8'($urandom_range(0, 254)), 32'($urandom)});
        run_random_phase(25, 10);
        // back to the reset base, many new paths to run the pool dry
        write_pool_base(flpte_pkg::BASE_RESET);
        run_random_phase(100, 30);

        drain_requests();
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("%0d requests sent, %0d responses checked, %0d pool base writes",
                 sent_count, checked, base_writes);
        $display("status codes seen, one bit per code from 7 down to 0: %b", status_seen);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/flpte_pkg.sv
rtl/flpte_ctrl.sv
rtl/flpte_dpath.sv
rtl/four_level_page_table_engine.sv
test/page_table_response_checker.sv
test/four_level_page_table_engine_tb.sv
